// ===== design/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// cas_pkg
// Types and constants shared by the cave smoothing block.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam logic OPEN_VAL = 1'b0;
  localparam logic WALL_VAL = 1'b1;

  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BIRTH_LIMIT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEATH_LIMIT = 2'd3;

  localparam logic [10:0] GRID_WIDTH_RST  = 11'd64;
  localparam logic [15:0] GRID_HEIGHT_RST = 16'd64;
  localparam logic [3:0]  BIRTH_LIMIT_RST = 4'd4;
  localparam logic [3:0]  DEATH_LIMIT_RST = 4'd4;

  localparam logic [8:0] WINDOW_WALLS = 9'h1FF;

  typedef struct packed {
    logic command;
    logic cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic frame_last;
  } out_item_t;

  // Control carried from the accept stage to the window stage.
  typedef struct packed {
    logic act;
    logic emit;
    logic drain;
    logic din;
    logic edge_left;
    logic edge_right;
    logic edge_top;
    logic edge_bottom;
    logic last;
  } stage_ctrl_t;

endpackage

// ===== design/cave_automaton_smoothing_top.sv =====
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_top
// One generation of cave smoothing over a binary grid in raster order.
// ----------------------------------------------------------------------------
// Usage:
// Cells enter on the in_ channel (valid/ready) in raster order, wall 1 and
// open 0. After the last cell, flush items drain the frame; a flush before
// the frame's last cell is taken and dropped. Each cell's next value leaves
// on the out_ channel, frame_last marking the final cell of the grid. The
// result for a cell is caused by the item grid_width + 1 places later in the
// stream; out_valid rises once that item has left the window stage and its
// result is in the output queue. One item is accepted per cycle while
// in_ready is high: the line stores are read at accept and the upper one is
// written back in the next cycle, so the read-modify-write loop sets the
// rate. The user must write registers on the cfg_ port only while the block
// is idle; the block does not enforce this. Reset clears counters, sets the
// window to walls and loads default registers; the line stores are not
// cleared. When the receiver stalls, up to two results are held in a small
// output queue and in_ready falls until room comes back.
// ----------------------------------------------------------------------------
module cave_automaton_smoothing_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cas_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cas_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [cas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cas_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;

  logic [10:0] grid_width_r;
  logic [15:0] grid_height_r;
  logic [3:0]  birth_limit_r;
  logic [3:0]  death_limit_r;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [15:0]      in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [15:0]      out_row_r, out_row_nxt;

  stage_ctrl_t      s1_r, s1_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [8:0]       win_r, win_nxt;

  out_item_t  fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  logic [31:0]      w_cl;
  logic [CNT_W-1:0] w_eff;
  logic [15:0]      h_eff;
  logic             accept, pop, push, drain, act;
  logic [2:0]       occ;
  logic             upper_rd, middle_rd, upper_we;
  logic [8:0]       win_upd;
  logic [3:0]       count;
  logic             centre, next_cell;
  out_item_t        result;

  always_comb begin
    if (grid_width_r < 11'd3) begin
      w_cl = 32'd3;
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      w_cl = 32'(MAX_WIDTH);
    end else begin
      w_cl = 32'(grid_width_r);
    end
    w_eff = w_cl[CNT_W-1:0];
    h_eff = (grid_height_r < 16'd3) ? 16'd3 : grid_height_r;
  end

  assign pop      = out_valid & out_ready;
  assign push     = s1_r.act & s1_r.emit;
  assign occ      = {1'b0, cnt_r} + {2'b0, push} - {2'b0, pop};
  assign in_ready = (occ <= 3'd1);
  assign accept   = in_valid & in_ready;
  assign drain    = (in_row_r >= h_eff);
  assign act      = drain | (in_data.command == CMD_CELL);

  cas_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (upper_we),
    .waddr (s1_col_r),
    .wdata (middle_rd),
    .raddr (in_col_r),
    .rdata (upper_rd)
  );

  cas_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (accept & act & ~drain),
    .waddr (in_col_r),
    .wdata (in_data.cell_in),
    .raddr (in_col_r),
    .rdata (middle_rd)
  );

  // Accept stage: positions, edge flags and frame bookkeeping.
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    s1_nxt      = '0;

    s1_nxt.drain       = drain;
    s1_nxt.din         = in_data.cell_in;
    s1_nxt.emit        = drain || (in_row_r >= 16'd2) ||
                         ((in_row_r == 16'd1) && (in_col_r != '0));
    s1_nxt.edge_left   = (out_col_r == '0);
    s1_nxt.edge_right  = (({1'b0, out_col_r} + CNT_W'(1)) >= w_eff);
    s1_nxt.edge_top    = (out_row_r == '0);
    s1_nxt.edge_bottom = (({1'b0, out_row_r} + 17'd1) >= {1'b0, h_eff});
    s1_nxt.last        = s1_nxt.edge_right & s1_nxt.edge_bottom;

    if (accept && act) begin
      s1_nxt.act = 1'b1;
      if (drain) begin
        if (({1'b0, in_col_r} + CNT_W'(1)) < w_eff) begin
          in_col_nxt = in_col_r + COL_W'(1);
        end
      end else if (({1'b0, in_col_r} + CNT_W'(1)) >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 16'd1;
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (s1_nxt.emit) begin
        if (s1_nxt.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (s1_nxt.edge_right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 16'd1;
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  // Window stage: line store data arrive, upper store is written back.
  assign upper_we = s1_r.act & ~s1_r.drain;
  assign win_upd  = {(s1_r.drain | s1_r.din), middle_rd, upper_rd, win_r[8:3]};
  assign centre   = win_upd[4];

  always_comb begin
    int k;
    int r;
    logic forced;
    count = '0;
    for (k = 0; k < 3; k++) begin
      for (r = 0; r < 3; r++) begin
        forced = ((k == 0) && s1_r.edge_left) || ((k == 2) && s1_r.edge_right) ||
                 ((r == 0) && s1_r.edge_top) || ((r == 2) && s1_r.edge_bottom);
        if (!((k == 1) && (r == 1))) begin
          count = count + {3'b0, (forced | win_upd[k*3+r])};
        end
      end
    end
    next_cell = centre;
    if (centre == WALL_VAL) begin
      if (count < birth_limit_r) begin
        next_cell = OPEN_VAL;
      end
    end else if (count > death_limit_r) begin
      next_cell = WALL_VAL;
    end
    result.cell_out   = next_cell;
    result.frame_last = s1_r.last;
    win_nxt = win_r;
    if (s1_r.act) begin
      win_nxt = (s1_r.emit && s1_r.last) ? WINDOW_WALLS : win_upd;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      birth_limit_r <= BIRTH_LIMIT_RST;
      death_limit_r <= DEATH_LIMIT_RST;
      in_col_r      <= '0;
      in_row_r      <= '0;
      out_col_r     <= '0;
      out_row_r     <= '0;
      s1_r          <= '0;
      win_r         <= WINDOW_WALLS;
      wr_ptr_r      <= 1'b0;
      rd_ptr_r      <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[10:0];
          REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[15:0];
          REG_BIRTH_LIMIT: birth_limit_r <= cfg_wdata[3:0];
          REG_DEATH_LIMIT: death_limit_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      s1_r      <= s1_nxt;
      win_r     <= win_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r <= in_col_r;
    if (push) begin
      fifo_r[wr_ptr_r] <= result;
    end
  end

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output queue over capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < 2'd2) || pop)
    else $error("result pushed into a full queue");

  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (upper_we && accept) |-> (in_col_r != s1_col_r))
    else $error("line store read collides with write-back");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.act && s1_r.emit && s1_r.last) |=> (win_r == WINDOW_WALLS) &&
    (in_row_r == 16'd0) && (out_row_r == 16'd0))
    else $error("frame state not cleared after final cell");
`endif

endmodule

// ===== design/cas_ram.sv =====
// ----------------------------------------------------------------------------
// cas_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cas_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
